// ===== src/rgb2hsv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rgb2hsv_pkg;

    // Hue is an angle in 1/64 degree: a full turn and one 60 degree sector
    localparam int HUE_BITS      = 15;
    localparam int HUE_TURN      = 23040;
    localparam int HUE_SECTOR    = 3840;
    // 3840 < 2^12, so the in-sector quotient fits in this many bits
    localparam int HUE_FRAC_BITS = 12;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

endpackage

`default_nettype wire

// ===== src/rgb_to_hsv_conversion_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RGB to HSV colour conversion, one pixel per clock. Value is the largest
// component, saturation is floor(FS * (max - min) / max) with FS the full-scale
// code, and hue is in 1/64 degree (0 to 23039); a grey pixel gives hue and
// saturation of 0. The pipeline takes a new pixel every cycle and passes it through
// the stage 1 register, the numerator register, one divider stage per quotient bit
// and the output register: both divisions run as restoring dividers with
// one quotient bit per stage. A stall at the output freezes the whole pipeline.
module rgb_to_hsv_conversion_unit
    import rgb2hsv_pkg::*;
#(
    parameter int COMPONENT_BITS = 8
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      pix_valid,
    output logic                           pix_ready,
    input  wire logic [COMPONENT_BITS-1:0] red_in,
    input  wire logic [COMPONENT_BITS-1:0] green_in,
    input  wire logic [COMPONENT_BITS-1:0] blue_in,

    output logic                           hsv_valid,
    input  wire logic                      hsv_ready,
    output logic [HUE_BITS-1:0]            hue_out,
    output logic [COMPONENT_BITS-1:0]      saturation_out,
    output logic [COMPONENT_BITS-1:0]      value_out
);

    localparam int CB    = COMPONENT_BITS;
    // quotient bits resolved; covers both the hue and the saturation quotient
    localparam int STEPS = (CB > HUE_FRAC_BITS) ? CB : HUE_FRAC_BITS;
    localparam int NUM_W = CB + STEPS;

    localparam logic [HUE_BITS-1:0] HUE_TURN_C  = HUE_BITS'(HUE_TURN);
    localparam logic [HUE_BITS-1:0] OFF_GREEN_C = HUE_BITS'(2 * HUE_SECTOR);
    localparam logic [HUE_BITS-1:0] OFF_BLUE_C  = HUE_BITS'(4 * HUE_SECTOR);

    // work word: partial remainder on top, numerator bits shifting out and
    // quotient bits shifting in below
    typedef struct packed {
        logic [NUM_W-1:0] hue_work;
        logic [NUM_W-1:0] sat_work;
        logic [CB-1:0]    delta;
        logic [CB-1:0]    hi;
        logic             neg;
        sector_t          sector;
        logic             grey;
    } div_t;

    logic                 adv;

    logic                 s1_valid_reg;
    logic [CB-1:0]        s1_hi_reg;
    logic [CB-1:0]        s1_delta_reg;
    logic [CB-1:0]        s1_absdiff_reg;
    logic                 s1_neg_reg;
    sector_t              s1_sector_reg;

    logic [CB-1:0]        s1_hi_next;
    logic [CB-1:0]        s1_lo_next;
    logic [CB-1:0]        diff_a;
    logic [CB-1:0]        diff_b;
    logic [CB:0]          diff_full;
    logic [CB-1:0]        s1_absdiff_next;
    sector_t              s1_sector_next;

    logic [NUM_W-1:0]     hue_num;
    logic [NUM_W-1:0]     sat_num;
    div_t                 div_next;

    logic [STEPS:0]       div_valid_reg;
    div_t                 div_reg [0:STEPS];

    logic                 hsv_valid_reg;
    logic [HUE_BITS-1:0]  hue_reg;
    logic [CB-1:0]        sat_reg;
    logic [CB-1:0]        value_reg;

    logic [HUE_BITS-1:0]  hue_next;
    logic [HUE_BITS-1:0]  hue_off;
    logic [HUE_BITS-1:0]  hue_q;
    logic [HUE_BITS-1:0]  hue_mag;
    logic                 hue_rem_nz;

    function automatic div_t div_step(div_t x);
        div_t        y;
        logic [CB:0] th;
        logic [CB:0] ts;
        y  = x;
        th = {x.hue_work[NUM_W-1:STEPS], x.hue_work[STEPS-1]};
        if (th >= {1'b0, x.delta})
        begin
            th         = th - {1'b0, x.delta};
            y.hue_work = {th[CB-1:0], x.hue_work[STEPS-2:0], 1'b1};
        end
        else
        begin
            y.hue_work = {th[CB-1:0], x.hue_work[STEPS-2:0], 1'b0};
        end
        ts = {x.sat_work[NUM_W-1:STEPS], x.sat_work[STEPS-1]};
        if (ts >= {1'b0, x.hi})
        begin
            ts         = ts - {1'b0, x.hi};
            y.sat_work = {ts[CB-1:0], x.sat_work[STEPS-2:0], 1'b1};
        end
        else
        begin
            y.sat_work = {ts[CB-1:0], x.sat_work[STEPS-2:0], 1'b0};
        end
        return y;
    endfunction

    // whole pipeline moves unless a finished result is held at the output
    assign adv       = !hsv_valid_reg || hsv_ready;
    assign pix_ready = adv;

    // stage 1: max, min, sector and signed difference
    always_comb
    begin
        s1_hi_next = red_in;
        s1_lo_next = red_in;
        if (green_in > s1_hi_next) s1_hi_next = green_in;
        if (blue_in  > s1_hi_next) s1_hi_next = blue_in;
        if (green_in < s1_lo_next) s1_lo_next = green_in;
        if (blue_in  < s1_lo_next) s1_lo_next = blue_in;

        if (red_in == s1_hi_next)
        begin
            s1_sector_next = SEC_RED;
            diff_a         = green_in;
            diff_b         = blue_in;
        end
        else if (green_in == s1_hi_next)
        begin
            s1_sector_next = SEC_GREEN;
            diff_a         = blue_in;
            diff_b         = red_in;
        end
        else
        begin
            s1_sector_next = SEC_BLUE;
            diff_a         = red_in;
            diff_b         = green_in;
        end
        diff_full       = {1'b0, diff_a} - {1'b0, diff_b};
        s1_absdiff_next = diff_full[CB] ? (diff_b - diff_a) : diff_full[CB-1:0];
    end

    // stage 2: numerators, 3840 = 4096 - 256 and FS * delta = (delta << CB) - delta
    always_comb
    begin
        hue_num = NUM_W'({s1_absdiff_reg, 12'b0}) - NUM_W'({s1_absdiff_reg, 8'b0});
        sat_num = NUM_W'({s1_delta_reg, {CB{1'b0}}}) - NUM_W'(s1_delta_reg);

        div_next.hue_work = hue_num;
        div_next.sat_work = sat_num;
        div_next.delta    = s1_delta_reg;
        div_next.hi       = s1_hi_reg;
        div_next.neg      = s1_neg_reg;
        div_next.sector   = s1_sector_reg;
        div_next.grey     = (s1_delta_reg == '0);
    end

    // final stage: floor toward minus infinity, sector offset and wrap
    always_comb
    begin
        unique case (div_reg[STEPS].sector)
            SEC_RED:   hue_off = '0;
            SEC_GREEN: hue_off = OFF_GREEN_C;
            SEC_BLUE:  hue_off = OFF_BLUE_C;
            default:   hue_off = '0;
        endcase
        hue_q      = HUE_BITS'(div_reg[STEPS].hue_work[HUE_FRAC_BITS-1:0]);
        hue_rem_nz = |div_reg[STEPS].hue_work[NUM_W-1:STEPS];
        hue_mag    = hue_q + HUE_BITS'(hue_rem_nz);

        if (div_reg[STEPS].grey)
            hue_next = '0;
        else if (!div_reg[STEPS].neg)
            hue_next = hue_off + hue_q;
        else if (hue_off >= hue_mag)
            hue_next = hue_off - hue_mag;
        else
            hue_next = hue_off + HUE_TURN_C - hue_mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            div_valid_reg <= '0;
            hsv_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= pix_valid;
            div_valid_reg <= {div_valid_reg[STEPS-1:0], s1_valid_reg};
            hsv_valid_reg <= div_valid_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hi_reg      <= s1_hi_next;
            s1_delta_reg   <= s1_hi_next - s1_lo_next;
            s1_absdiff_reg <= s1_absdiff_next;
            s1_neg_reg     <= diff_full[CB];
            s1_sector_reg  <= s1_sector_next;

            div_reg[0] <= div_next;
            for (int k = 0; k < STEPS; k++)
            begin
                div_reg[k+1] <= div_step(div_reg[k]);
            end

            hue_reg   <= hue_next;
            sat_reg   <= div_reg[STEPS].grey ? '0 : div_reg[STEPS].sat_work[CB-1:0];
            value_reg <= div_reg[STEPS].hi;
        end
    end

    assign hsv_valid      = hsv_valid_reg;
    assign hue_out        = hue_reg;
    assign saturation_out = sat_reg;
    assign value_out      = value_reg;

endmodule

`default_nettype wire

// ===== src/rgb2hsv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rgb2hsv_checker
    import rgb2hsv_pkg::*;
#(
    parameter int COMPONENT_BITS = 8
)
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      pix_ready,
    input wire logic                      hsv_valid,
    input wire logic                      hsv_ready,
    input wire logic [HUE_BITS-1:0]       hue_out,
    input wire logic [COMPONENT_BITS-1:0] saturation_out,
    input wire logic [COMPONENT_BITS-1:0] value_out
);

    // a result held at the output stays put until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue_out)
            && $stable(saturation_out) && $stable(value_out))
        else $error("result changed while stalled");

    // a stalled output freezes the pipeline, so no new pixel may enter
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |-> !pix_ready)
        else $error("pixel taken while output stalled");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hue_out < HUE_BITS'(HUE_TURN))
        else $error("hue out of range");

    // zero saturation only for grey, and grey has zero hue
    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && saturation_out == '0 |-> hue_out == '0)
        else $error("grey pixel with nonzero hue");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && value_out == '0 |-> saturation_out == '0)
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_conversion_unit rgb2hsv_checker #(
    .COMPONENT_BITS (COMPONENT_BITS)
) u_rgb2hsv_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pix_ready      (pix_ready),
    .hsv_valid      (hsv_valid),
    .hsv_ready      (hsv_ready),
    .hue_out        (hue_out),
    .saturation_out (saturation_out),
    .value_out      (value_out)
);

`default_nettype wire

// ===== tb/sv/tb_rgb_to_hsv_conversion_unit.sv =====
`timescale 1ns / 1ps

module tb_rgb_to_hsv_conversion_unit;
    import rgb2hsv_pkg::*;

    localparam int COMPONENT_BITS = 8;
    localparam int FULL_SCALE     = (1 << COMPONENT_BITS) - 1;
    localparam int RANDOM_PIXELS  = 1700;
    localparam int BLOCK_PIXELS   = 100;
    localparam int STALL_LIMIT    = 1000;
    localparam int DRAIN_CYCLES   = 40;

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    typedef struct packed {
        logic [HUE_BITS-1:0] hue;
        comp_t               sat;
        comp_t               val;
    } hsv_t;

    typedef struct packed {
        comp_t r;
        comp_t g;
        comp_t b;
    } rgb_t;

    class hsv_scoreboard;
        hsv_t expected_hsv[$];
        int   mismatches;
        int   results_checked;
        int   greys_seen;

        function new();
            mismatches      = 0;
            results_checked = 0;
            greys_seen      = 0;
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction

        task flag_mismatch(string what, int got, int want);
            mismatches++;
            if (mismatches <= 60)
                $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got,
                         want);
        endtask

        // Work out hue, saturation and value for a pixel taken by the block
        function void note_pixel(rgb_t px);
            hsv_t    e;
            int      hi;
            int      lo;
            int      delta;
            int      diff;
            int      num;
            int      quo;
            int      offset;
            int      h;
            sector_t sec;

            hi = px.r;
            lo = px.r;
            if (px.g > hi) hi = px.g;
            if (px.b > hi) hi = px.b;
            if (px.g < lo) lo = px.g;
            if (px.b < lo) lo = px.b;
            delta = hi - lo;
            e.val = comp_t'(hi);
            e.hue = '0;
            e.sat = '0;
            if (delta == 0) begin
                greys_seen++;
            end
            else
            begin
                e.sat = comp_t'((FULL_SCALE * delta) / hi);
                // ties favour red, then green
                if (px.r == hi)
                    sec = SEC_RED;
                else if (px.g == hi)
                    sec = SEC_GREEN;
                else
                    sec = SEC_BLUE;
                case (sec)
                    SEC_RED:
                    begin
                        diff   = int'(px.g) - int'(px.b);
                        offset = 0;
                    end
                    SEC_GREEN:
                    begin
                        diff   = int'(px.b) - int'(px.r);
                        offset = 2 * HUE_SECTOR;
                    end
                    default:
                    begin
                        diff   = int'(px.r) - int'(px.g);
                        offset = 4 * HUE_SECTOR;
                    end
                endcase
                num = diff * HUE_SECTOR;
                quo = num / delta;
                // round toward minus infinity, not zero
                if ((num % delta) != 0 && num < 0)
                    quo = quo - 1;
                h = offset + quo;
                if (h < 0)
                    h = h + HUE_TURN;
                e.hue = HUE_BITS'(h);
            end
            expected_hsv.push_back(e);
        endfunction

        task check_result(hsv_t got);
            hsv_t want;

            results_checked++;
            if (expected_hsv.size() == 0) begin
                flag_mismatch("unexpected result, hue", int'(got.hue), -1);
            end
            else
            begin
                want = expected_hsv.pop_front();
                if (got.hue !== want.hue)
                    flag_mismatch("hue_out", int'(got.hue), int'(want.hue));
                if (got.sat !== want.sat)
                    flag_mismatch("saturation_out", int'(got.sat), int'(want.sat));
                if (got.val !== want.val)
                    flag_mismatch("value_out", int'(got.val), int'(want.val));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                pix_valid;
    logic                pix_ready;
    comp_t               red_in;
    comp_t               green_in;
    comp_t               blue_in;
    logic                hsv_valid;
    logic                hsv_ready;
    logic [HUE_BITS-1:0] hue_out;
    comp_t               saturation_out;
    comp_t               value_out;

    hsv_scoreboard sb;
    bit            pix_steady;
    bit            hsv_steady;
    int            pixels_sent;
    int            idle_cycles;

    rgb_to_hsv_conversion_unit #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .red_in        (red_in),
        .green_in      (green_in),
        .blue_in       (blue_in),
        .hsv_valid     (hsv_valid),
        .hsv_ready     (hsv_ready),
        .hue_out       (hue_out),
        .saturation_out(saturation_out),
        .value_out     (value_out)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Called at a rising edge; returns at the edge where the transfer happens
    task send_pixel(rgb_t px);
        int gap;

        gap = pix_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        red_in    <= px.r;
        green_in  <= px.g;
        blue_in   <= px.b;
        do
            @(posedge clk);
        while (!pix_ready);
        sb.note_pixel(px);
        pixels_sent++;
    endtask

    task send_rgb(int r, int g, int b);
        rgb_t px;

        px.r = comp_t'(r);
        px.g = comp_t'(g);
        px.b = comp_t'(b);
        send_pixel(px);
    endtask

    // Hold the input off until the pipeline has handed back everything
    task drain_pipeline();
        pix_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function comp_t edge_component();
        case ($urandom_range(0, 3))
            0: return comp_t'(0);
            1: return comp_t'(1);
            2: return comp_t'(FULL_SCALE - 1);
            default: return comp_t'(FULL_SCALE);
        endcase
    endfunction

    // Mix of plain random pixels, greys, two-way ties and near-extreme values
    function rgb_t random_pixel();
        rgb_t  px;
        comp_t c;

        px.r = comp_t'($urandom);
        px.g = comp_t'($urandom);
        px.b = comp_t'($urandom);
        case ($urandom_range(0, 9))
            0:
            begin
                px.g = px.r;
                px.b = px.r;
            end
            1: px.g = px.r;
            2:
            begin
                c    = comp_t'($urandom);
                px.b = c;
                if ($urandom_range(0, 1)) px.r = c;
                else px.g = c;
            end
            3:
            begin
                px.r = edge_component();
                px.g = edge_component();
                px.b = edge_component();
            end
            4:
            begin
                // delta of at most two around a random level
                c    = comp_t'($urandom_range(2, FULL_SCALE - 2));
                px.r = c + comp_t'($urandom_range(0, 2)) - comp_t'(1);
                px.g = c + comp_t'($urandom_range(0, 2)) - comp_t'(1);
                px.b = c + comp_t'($urandom_range(0, 2)) - comp_t'(1);
            end
            default: ;
        endcase
        return px;
    endfunction

    // Result side: random stalls per transfer, with quiet stretches
    initial
    begin
        int stall;

        hsv_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = hsv_steady ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                hsv_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            hsv_ready <= 1'b1;
            do
                @(posedge clk);
            while (!hsv_valid);
            sb.check_result('{hue: hue_out, sat: saturation_out, val: value_out});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((pix_valid && pix_ready) || (hsv_valid && hsv_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
                $display("tb_rgb_to_hsv_conversion_unit NOT OK");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    initial
    begin
        int blk;
        int k;

        sb          = new();
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        red_in      = '0;
        green_in    = '0;
        blue_in     = '0;
        pix_steady  = 1'b0;
        hsv_steady  = 1'b0;
        pixels_sent = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // greys, primaries, secondaries and the awkward corners of each sector
        send_rgb(0, 0, 0);
        send_rgb(FULL_SCALE, FULL_SCALE, FULL_SCALE);
        send_rgb(128, 128, 128);
        send_rgb(FULL_SCALE, 0, 0);
        send_rgb(0, FULL_SCALE, 0);
        send_rgb(0, 0, FULL_SCALE);
        send_rgb(FULL_SCALE, FULL_SCALE, 0);
        send_rgb(0, FULL_SCALE, FULL_SCALE);
        send_rgb(FULL_SCALE, 0, FULL_SCALE);
        send_rgb(FULL_SCALE, 0, 1);
        send_rgb(1, 0, 0);
        send_rgb(0, 1, 1);
        send_rgb(FULL_SCALE, FULL_SCALE - 1, FULL_SCALE - 1);
        send_rgb(FULL_SCALE - 1, FULL_SCALE, FULL_SCALE - 1);
        send_rgb(FULL_SCALE - 1, FULL_SCALE - 1, FULL_SCALE);
        send_rgb(1, 0, FULL_SCALE);
        send_rgb(0, FULL_SCALE, 1);
        send_rgb(FULL_SCALE, 1, 0);
        send_rgb(10, 20, 30);
        send_rgb(200, 100, 50);
        send_rgb(170, 85, 0);
        send_rgb(1, 1, 0);
        drain_pipeline();

        for (blk = 0; blk < RANDOM_PIXELS / BLOCK_PIXELS; blk++) begin
            pix_steady = ($urandom_range(0, 3) == 0);
            hsv_steady = ($urandom_range(0, 3) == 0);
            for (k = 0; k < BLOCK_PIXELS; k++)
                send_pixel(random_pixel());
            if (blk == 8)
                drain_pipeline();
        end
        pix_steady = 1'b0;
        hsv_steady = 1'b0;

        drain_pipeline();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pixels (%0d grey) under random input gaps and output stalls;",
                 pixels_sent, sb.greys_seen);
        $display("checked %0d results, %0d field mismatches, %0d still outstanding.",
                 sb.results_checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_rgb_to_hsv_conversion_unit OK");
        else
            $display("tb_rgb_to_hsv_conversion_unit NOT OK");
        $finish;
    end

endmodule

// ===== rgb_to_hsv_conversion_unit.f =====
src/rgb2hsv_pkg.sv
src/rgb_to_hsv_conversion_unit.sv
src/rgb2hsv_checker.sv
tb/sv/tb_rgb_to_hsv_conversion_unit.sv
